// ===== sv/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
`timescale 1ns / 1ps

package lpd_pkg;

    // Frame header layout.
    localparam int HEADER_BYTES = 4;
    localparam int LEN_BITS     = 28;

    // Command codes carried by the input transaction.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Status codes of a result transaction.
    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_POP      = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_byte;
        logic [3:0]  frame_type;
        logic [9:0]  payload_length;
        logic [10:0] fill_level;
    } t_out_item;

    typedef enum logic {
        OP_PUSH,
        OP_POP
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

endpackage

// ===== sv/length_prefixed_deframer_top.sv =====
// Top level of the length-prefixed deframer: command queue plus ring-store engine.
`timescale 1ns / 1ps
// A push result is registered in the engine's output register once the queue passes the command on.
// Throughput: one push per cycle while the output register is free; a pop that delivers a mid-frame
// byte passes through S_POP_WAIT for its memory read; a pop that ends a frame reloads the four
// header bytes in S_HDR_LOAD through the single memory read port.
// Reset is synchronous and active low; it clears pointers, counts and the queue.
// The ring memory is not cleared, since only held bytes are ever read.

module length_prefixed_deframer_top
    import lpd_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Queued commands pass from the front to the back as one transaction each.
    logic op_valid;
    logic op_ready;
    t_op  op;

    // The front end takes input transactions, tags each as a push or a pop and holds
    // up to two of them, so the input side keeps moving while the engine is busy.
    lpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    // The back end owns the ring memory, the head pointer, the fill count and a copy of
    // the header at the head. It produces exactly one result transaction per command,
    // held in an output register until the consumer takes it.
    lpd_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

// ===== sv/lpd_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
`timescale 1ns / 1ps

module lpd_front
    import lpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_op_valid,
    input  logic     i_op_ready,
    output t_op      o_op
);

    t_op               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;
    t_op               op_in;

    assign o_in_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_op_valid = (r_count != '0);
    assign o_op       = r_q[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_op_valid && i_op_ready;

    always_comb begin
        op_in.kind = (i_in_data.command == CMD_POP) ? OP_POP : OP_PUSH;
        op_in.data = i_in_data.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= op_in;
        end
    end

endmodule

// ===== sv/lpd_back.sv =====
// Back end: ring memory, header tracking and result generation.
`timescale 1ns / 1ps

module lpd_back
    import lpd_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_op_valid,
    output logic      o_op_ready,
    input  t_op       i_op,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [FW:0]         CAP_X   = (FW + 1)'(CAPACITY);
    localparam logic [FW:0]         HDR_X   = (FW + 1)'(HEADER_BYTES);
    localparam logic [FW-1:0]       CAP_F   = FW'(CAPACITY);
    localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(CAPACITY - HEADER_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_HDR_LOAD
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [FW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_ro, n_ro;
    logic [3:0][7:0] r_hdr, n_hdr;
    logic [2:0]      r_hcnt, n_hcnt;
    logic [7:0]      r_pend_byte, n_pend_byte;
    logic            r_pend_valid, n_pend_valid;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic [7:0]      r_mem [CAPACITY];
    logic [7:0]      r_rd_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;

    logic                out_free;
    logic                cur_ready;
    logic [LEN_BITS-1:0] cur_full_len;
    logic [AW-1:0]       cur_len;
    logic [FW:0]         total;
    logic [AW-1:0]       ro_inc;
    logic [2:0]          hcnt_m1;

    function automatic logic [AW-1:0] wrap(input logic [FW:0] s);
        logic [FW:0] t;
        t = (s >= CAP_X) ? (s - CAP_X) : s;
        return t[AW-1:0];
    endfunction

    function automatic logic [LEN_BITS-1:0] hdr_len(input logic [3:0][7:0] h);
        return {h[3][3:0], h[2], h[1], h[0]};
    endfunction

    function automatic logic is_bad(input logic [FW-1:0] f, input logic [3:0][7:0] h);
        return ((FW + 1)'(f) >= HDR_X) && (hdr_len(h) > MAX_LEN);
    endfunction

    function automatic logic is_ready(input logic [FW-1:0] f, input logic [3:0][7:0] h);
        logic [LEN_BITS-1:0] l;
        l = hdr_len(h);
        return ((FW + 1)'(f) >= HDR_X) && (l <= MAX_LEN)
            && ((FW + 1)'(f) >= HDR_X + (FW + 1)'(l[AW-1:0]));
    endfunction

    function automatic t_out_item build(
        input logic [2:0]      st,
        input logic [7:0]      b,
        input logic            v,
        input logic            lst,
        input logic [FW-1:0]   f,
        input logic [3:0][7:0] h
    );
        t_out_item           r;
        logic                rdy;
        logic [FW+10:0]      fw;
        logic [LEN_BITS-1:0] l;
        rdy              = is_ready(f, h);
        fw               = (FW + 11)'(f);
        l                = hdr_len(h);
        r.status         = st;
        r.out_byte       = b;
        r.byte_valid     = v;
        r.last_byte      = lst;
        r.frame_type     = rdy ? h[3][7:4] : 4'd0;
        r.payload_length = rdy ? l[9:0] : 10'd0;
        r.fill_level     = fw[10:0];
        return r;
    endfunction

    assign out_free     = !r_out_valid || i_out_ready;
    assign cur_ready    = is_ready(r_fill, r_hdr);
    assign cur_full_len = hdr_len(r_hdr);
    assign cur_len      = cur_full_len[AW-1:0];
    assign total        = HDR_X + (FW + 1)'(cur_len);
    assign ro_inc       = r_ro + 1'b1;
    assign hcnt_m1      = r_hcnt - 3'd1;
    assign o_out_valid  = r_out_valid;
    assign o_out        = r_out;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fill       = r_fill;
        n_ro         = r_ro;
        n_hdr        = r_hdr;
        n_hcnt       = r_hcnt;
        n_pend_byte  = r_pend_byte;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        o_op_ready   = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid && out_free) begin
                    o_op_ready  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_op.kind == OP_PUSH) begin
                        if (r_fill == CAP_F) begin
                            // Full store: drop the byte and start over.
                            n_head = '0;
                            n_fill = '0;
                            n_ro   = '0;
                            n_out  = build(ST_OVERFLOW, 8'd0, 1'b0, 1'b0, '0, r_hdr);
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = wrap((FW + 1)'(r_head) + (FW + 1)'(r_fill));
                            n_fill  = r_fill + 1'b1;
                            if ((FW + 1)'(r_fill) < HDR_X) begin
                                n_hdr[r_fill[1:0]] = i_op.data;
                            end
                            if (is_bad(n_fill, n_hdr)) begin
                                n_head = '0;
                                n_fill = '0;
                                n_ro   = '0;
                                n_out  = build(ST_BAD_LEN, 8'd0, 1'b0, 1'b0, '0, n_hdr);
                            end else begin
                                n_out = build(is_ready(n_fill, n_hdr) ? ST_READY : ST_STORED,
                                              8'd0, 1'b0, 1'b0, n_fill, n_hdr);
                            end
                        end
                    end else if (!cur_ready) begin
                        n_out = build(ST_NONE, 8'd0, 1'b0, 1'b0, r_fill, r_hdr);
                    end else if (r_ro < cur_len) begin
                        // Fetch the next payload byte; the result is built from the registered read data in S_POP_WAIT.
                        n_out_valid = 1'b0;
                        rd_en       = 1'b1;
                        rd_addr     = wrap((FW + 1)'(r_head) + HDR_X + (FW + 1)'(r_ro));
                        n_state     = S_POP_WAIT;
                    end else begin
                        // Empty frame: consume it without a byte.
                        n_out_valid  = 1'b0;
                        n_pend_byte  = 8'd0;
                        n_pend_valid = 1'b0;
                        n_head       = wrap((FW + 1)'(r_head) + total);
                        n_fill       = ((FW + 1)'(r_fill) >= total) ?
                                       FW'((FW + 1)'(r_fill) - total) : '0;
                        n_ro         = '0;
                        n_hcnt       = '0;
                        n_state      = S_HDR_LOAD;
                    end
                end
            end
            S_POP_WAIT: begin
                if (ro_inc == cur_len) begin
                    n_pend_byte  = r_rd_data;
                    n_pend_valid = 1'b1;
                    n_head       = wrap((FW + 1)'(r_head) + total);
                    n_fill       = ((FW + 1)'(r_fill) >= total) ?
                                   FW'((FW + 1)'(r_fill) - total) : '0;
                    n_ro         = '0;
                    n_hcnt       = '0;
                    n_state      = S_HDR_LOAD;
                end else begin
                    n_ro        = ro_inc;
                    n_out_valid = 1'b1;
                    n_out       = build(ST_POP, r_rd_data, 1'b1, 1'b0, r_fill, r_hdr);
                    n_state     = S_IDLE;
                end
            end
            S_HDR_LOAD: begin
                // One header byte is read per cycle; each lands in the next cycle.
                if (r_hcnt != 3'd4) begin
                    rd_en   = 1'b1;
                    rd_addr = wrap((FW + 1)'(r_head) + (FW + 1)'(r_hcnt));
                end
                if (r_hcnt != 3'd0) begin
                    n_hdr[hcnt_m1[1:0]] = r_rd_data;
                end
                n_hcnt = r_hcnt + 3'd1;
                if (r_hcnt == 3'd4) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (is_bad(r_fill, n_hdr)) begin
                        n_head = '0;
                        n_fill = '0;
                        n_ro   = '0;
                        n_out  = build(ST_BAD_LEN, r_pend_byte, r_pend_valid, 1'b1,
                                       '0, n_hdr);
                    end else begin
                        n_out = build(ST_POP, r_pend_byte, r_pend_valid, 1'b1,
                                      r_fill, n_hdr);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_ro        <= '0;
            r_hcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_ro        <= n_ro;
            r_hcnt      <= n_hcnt;
            r_out_valid <= n_out_valid;
        end
        r_hdr        <= n_hdr;
        r_pend_byte  <= n_pend_byte;
        r_pend_valid <= n_pend_valid;
        r_out        <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_op.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= CAP_F))
        else $error("fill count above capacity");

    a_no_bad_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !is_bad(r_fill, r_hdr))
        else $error("bad header length left in the store");

    a_offset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !cur_ready) |-> (r_ro == '0))
        else $error("read offset held without a ready frame");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_byte) |->
            (r_out.status == ST_POP || r_out.status == ST_BAD_LEN))
        else $error("last byte flagged on a non-pop result");

endmodule

// ===== verif/length_prefixed_deframer_top_tb.sv =====
// Self-checking testbench for the length-prefixed deframer: directed frames, long frames, random streams.
`timescale 1ns / 1ps

module length_prefixed_deframer_top_tb;
    import lpd_pkg::*;

    localparam int CAPACITY     = 1024;
    localparam int MAX_PAYLOAD  = CAPACITY - HEADER_BYTES;
    localparam int RANDOM_ITEMS = 580;
    // The receiver holds off this long once, so that the command queue fills up.
    localparam int HOLD_CYCLES  = 300;
    // Quiet time after the last result, with a safe margin over a pop that ends a frame.
    localparam int QUIET_CYCLES = 24;
    localparam int REPORT_LIMIT = 40;

    // The scoreboard keeps its own image of the ring store and the ready frame.
    // Every accepted command is run through it at once, and the result it yields
    // waits in a queue until the block delivers the matching transaction.
    class deframe_scoreboard;
        logic [7:0]  ring [CAPACITY];
        int unsigned head;
        int unsigned fill;
        int unsigned rd_off;
        int unsigned rdy_len;
        logic [3:0]  rdy_type;
        bit          frame_rdy;
        t_out_item   awaited_results[$];
        int          errors;
        int          pushes;
        int          pops;
        int          frames_done;
        int          status_count[8];

        function new();
            empty_store();
        endfunction

        function void empty_store();
            head      = 0;
            fill      = 0;
            rd_off    = 0;
            rdy_len   = 0;
            rdy_type  = '0;
            frame_rdy = 1'b0;
        endfunction

        function logic [7:0] byte_at(int unsigned off);
            return ring[(head + off) % CAPACITY];
        endfunction

        // Looks at the header at the head of the store. Returns 1 when its
        // length is illegal and the store has been emptied.
        function bit refresh_header();
            logic [31:0] hdr;
            int unsigned len;
            frame_rdy = 1'b0;
            if (fill < HEADER_BYTES)
                return 1'b0;
            hdr = {byte_at(3), byte_at(2), byte_at(1), byte_at(0)};
            len = 32'(hdr[LEN_BITS-1:0]);
            if (len > CAPACITY - HEADER_BYTES) begin
                empty_store();
                return 1'b1;
            end
            if (fill < HEADER_BYTES + len)
                return 1'b0;
            frame_rdy = 1'b1;
            rdy_type  = hdr[31:LEN_BITS];
            rdy_len   = len;
            return 1'b0;
        endfunction

        function void note_command(t_in_item item);
            t_out_item   want;
            int unsigned span;
            want = '0;
            if (item.command == CMD_PUSH) begin
                pushes++;
                if (fill >= CAPACITY) begin
                    empty_store();
                    want.status = ST_OVERFLOW;
                end else begin
                    ring[(head + fill) % CAPACITY] = item.data_byte;
                    fill++;
                    if (refresh_header())
                        want.status = ST_BAD_LEN;
                    else
                        want.status = frame_rdy ? ST_READY : ST_STORED;
                end
            end else if (!frame_rdy) begin
                pops++;
                want.status = ST_NONE;
            end else begin
                pops++;
                want.status = ST_POP;
                if (rd_off < rdy_len) begin
                    want.out_byte   = byte_at(HEADER_BYTES + rd_off);
                    want.byte_valid = 1'b1;
                    rd_off++;
                end
                if (rd_off >= rdy_len) begin
                    span           = HEADER_BYTES + rdy_len;
                    want.last_byte = 1'b1;
                    head           = (head + span) % CAPACITY;
                    fill           = (fill >= span) ? fill - span : 0;
                    rd_off         = 0;
                    frames_done++;
                    if (refresh_header())
                        want.status = ST_BAD_LEN;
                end
            end
            if (frame_rdy) begin
                want.frame_type     = rdy_type;
                want.payload_length = 10'(rdy_len);
            end
            want.fill_level = 11'(fill);
            status_count[want.status]++;
            awaited_results.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            string     bad_fields;
            if (awaited_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with nothing awaited, got %p", $time, got);
                return;
            end
            want       = awaited_results.pop_front();
            bad_fields = "";
            if (got.status !== want.status)                 bad_fields = {bad_fields, " status"};
            if (got.out_byte !== want.out_byte)             bad_fields = {bad_fields, " out_byte"};
            if (got.byte_valid !== want.byte_valid)         bad_fields = {bad_fields, " byte_valid"};
            if (got.last_byte !== want.last_byte)           bad_fields = {bad_fields, " last_byte"};
            if (got.frame_type !== want.frame_type)         bad_fields = {bad_fields, " frame_type"};
            if (got.payload_length !== want.payload_length) bad_fields = {bad_fields, " payload_length"};
            if (got.fill_level !== want.fill_level)         bad_fields = {bad_fields, " fill_level"};
            if (bad_fields != "") begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: mismatch in%s: expected %p, got %p",
                             $time, bad_fields, want, got);
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    deframe_scoreboard sb;

    // Idle rates in percent, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req      = 1'b0;

    length_prefixed_deframer_top #(.CAPACITY(CAPACITY)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Both handshakes are sampled at the rising edge, where every signal still
    // holds the value it had before the edge. A command transaction is fed to
    // the scoreboard before any result of the same edge is checked; since each result
    // is registered behind its command in the queue and the engine, the order cannot matter anyway.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_command(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // Receiver: random back-pressure at the current idle rate, plus one long
    // hold-off counted here when the stimulus asks for it.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one command transaction and returns at the edge that accepts it.
    // Valid stays high when the next call offers again at once, so a new item
    // follows without a bubble; otherwise the idle loop lowers it.
    task automatic send_item(input logic cmd, input logic [7:0] data);
        t_in_item item;
        item.command   = cmd;
        item.data_byte = data;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic pop_one();
        send_item(CMD_POP, 8'($urandom));
    endtask

    // Header bytes go out least significant first: length, then the type nibble.
    task automatic push_header(input logic [3:0] ftype, input logic [LEN_BITS-1:0] len);
        logic [31:0] hdr;
        hdr = {ftype, len};
        for (int i = 0; i < HEADER_BYTES; i++)
            send_item(CMD_PUSH, hdr[8*i +: 8]);
    endtask

    task automatic push_frame(input logic [3:0] ftype, input int len);
        push_header(ftype, LEN_BITS'(len));
        repeat (len) send_item(CMD_PUSH, 8'($urandom));
    endtask

    // A frame with no payload still takes one pop to be consumed.
    task automatic read_frame(input int len);
        repeat ((len == 0) ? 1 : len) pop_one();
    endtask

    // Either just past the longest legal length or a wild one.
    task automatic push_bad_header();
        logic [31:0] hdr;
        hdr = $urandom;
        if ($urandom_range(2) == 0)
            hdr[LEN_BITS-1:0] = LEN_BITS'(MAX_PAYLOAD + 1 + $urandom_range(2));
        else if (hdr[LEN_BITS-1:0] <= LEN_BITS'(MAX_PAYLOAD))
            hdr[16] = 1'b1;
        push_header(hdr[31:LEN_BITS], hdr[LEN_BITS-1:0]);
    endtask

    // Mostly short payloads, some zero length, a few long ones.
    function automatic int rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return 0;
        if (r < 80)
            return $urandom_range(8, 1);
        if (r < 95)
            return $urandom_range(40, 9);
        return $urandom_range(200, 41);
    endfunction

    // Lowers valid and waits until every awaited result has been delivered.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic directed_checks();
        // A pop into an empty store finds nothing ready.
        pop_one();
        // Zero-length frame with the highest type: one pop consumes it.
        push_header(4'hF, '0);
        read_frame(0);
        // Two-byte frame with extreme payload values; the early pop finds the
        // header alone and nothing ready.
        push_header(4'h0, LEN_BITS'(2));
        pop_one();
        send_item(CMD_PUSH, 8'h00);
        send_item(CMD_PUSH, 8'hFF);
        read_frame(2);
        // One byte past the longest legal payload clears the store.
        push_header(4'h0, LEN_BITS'(MAX_PAYLOAD + 1));
        // A good frame with an all-ones header queued behind it: the pop that
        // consumes the frame delivers its byte and then clears the store.
        push_header(4'h5, LEN_BITS'(1));
        send_item(CMD_PUSH, 8'hA5);
        push_header(4'hF, '1);
        pop_one();
    endtask

    task automatic long_frames();
        int lead;
        lead = $urandom_range(20, 1);
        // A short frame first, so the head sits off zero and the longest frame
        // wraps around the end of the store as it is written.
        push_frame(4'($urandom_range(15)), lead);
        read_frame(lead);
        // The longest frame fills the store to the brim; one more push overflows it.
        push_frame(4'($urandom_range(15)), MAX_PAYLOAD);
        send_item(CMD_PUSH, 8'($urandom));
    endtask

    // Each chunk leaves the store empty, so the stream stays framed even
    // after the broken sequences.
    task automatic random_chunk();
        int kind;
        int len_a;
        int len_b;
        int part;
        kind  = $urandom_range(99);
        len_a = rand_len();
        if (kind < 50) begin
            push_frame(4'($urandom_range(15)), len_a);
            read_frame(len_a);
        end else if (kind < 65) begin
            // A second frame arrives while the first is partly read out.
            len_b = rand_len();
            part  = (len_a == 0) ? 0 : $urandom_range(len_a - 1);
            push_frame(4'($urandom_range(15)), len_a);
            repeat (part) pop_one();
            push_frame(4'($urandom_range(15)), len_b);
            read_frame(len_a - part);
            read_frame(len_b);
        end else if (kind < 75) begin
            // A bad header behind a good frame clears the store on consume.
            push_frame(4'($urandom_range(15)), len_a);
            push_bad_header();
            read_frame(len_a);
        end else if (kind < 85) begin
            push_bad_header();
        end else if (kind < 92) begin
            repeat ($urandom_range(3, 1)) pop_one();
        end else begin
            // Pop in the middle of an incomplete frame, then complete it. If
            // the pop lands after the last byte, the final pop finds nothing.
            part = $urandom_range(len_a);
            push_header(4'($urandom_range(15)), LEN_BITS'(len_a));
            repeat (part) send_item(CMD_PUSH, 8'($urandom));
            pop_one();
            repeat (len_a - part) send_item(CMD_PUSH, 8'($urandom));
            read_frame(len_a);
        end
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct, input int count);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = items_sent + count;
        while (items_sent < stop_at)
            random_chunk();
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();
        long_frames();
        settle();

        // First phase: a slow receiver, with one long hold-off at its start
        // while the sender keeps offering, so the block stalls its input.
        hold_req = 1'b1;
        random_phase(18, 78, RANDOM_ITEMS / 3);
        // The sender pauses here until every result is out.
        settle();
        random_phase(78, 18, RANDOM_ITEMS / 3);
        settle();
        random_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        settle();
        repeat (QUIET_CYCLES) @(posedge i_clk);

        $display("Covered %0d pushes and %0d pops under three idle patterns; %0d frames consumed.",
                 sb.pushes, sb.pops, sb.frames_done);
        $display("Saw %0d overflow clears, %0d bad-length clears and %0d pops with nothing ready.",
                 sb.status_count[ST_OVERFLOW], sb.status_count[ST_BAD_LEN],
                 sb.status_count[ST_NONE]);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin
        #10_000_000;
        $display("Timeout with %0d results still awaited", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
